FILE: rtl/dqa_pkg.sv
// Shared types, constants and helpers for the two-queue admission buffer.
`default_nettype none
package dqa_pkg;

	localparam int HANDLE_BITS = 16;
	localparam int FIFO_DEPTH_DEFAULT = 64;
	localparam int ADDR_BITS = 16;
	localparam int LIMIT_BITS = 7;
	localparam int THR_BITS = LIMIT_BITS + 1;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_QUEUE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NODE_ADDRESS = 2'd1;

	localparam logic [LIMIT_BITS-1:0] QLIM_RESET = 7'd50;
	localparam logic [ADDR_BITS-1:0] NODE_RESET = 16'd0;
	localparam logic [THR_BITS-1:0] T1_RESET = THR_BITS'(50 / 3);
	localparam logic [THR_BITS-1:0] T2_RESET = THR_BITS'((50 * 2) / 3);

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] BS_ACCEPT = 2'd0;
	localparam logic [1:0] BS_FILTER = 2'd1;
	localparam logic [1:0] BS_REJECT = 2'd2;

	typedef struct packed {
		logic                   mode;
		logic [ADDR_BITS-1:0]   source_address;
		logic [HANDLE_BITS-1:0] packet_handle;
	} item_t;

	typedef struct packed {
		logic                   admitted;
		logic [1:0]             buffer_state;
		logic                   went_local;
		logic                   overflow_drop;
		logic                   out_valid;
		logic [HANDLE_BITS-1:0] out_handle;
		logic                   out_from_local;
	} result_t;

	// Thresholds and node address handed from the register block to the datapath.
	typedef struct packed {
		logic [THR_BITS-1:0]  t1;
		logic [THR_BITS-1:0]  t2;
		logic [ADDR_BITS-1:0] node;
	} thr_t;

	// Divide an 8-bit value by three: multiply by 171/512, exact for inputs below 512.
	function automatic logic [THR_BITS-1:0] div3(input logic [THR_BITS-1:0] x);
		logic [THR_BITS+8:0] prod;
		prod = (THR_BITS+9)'(x) * (THR_BITS+9)'(171);
		return prod[THR_BITS+8:9];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/dqa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module dqa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dqa_cfg.sv
// Configuration registers and the precomputed one-third and two-thirds thresholds.
`default_nettype none
module dqa_cfg
	import dqa_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	output thr_t                          thr
);

	logic [LIMIT_BITS-1:0] qlim;
	logic [THR_BITS-1:0]   t1_q;
	logic [THR_BITS-1:0]   t2_q;
	logic [ADDR_BITS-1:0]  node_q;

	assign qlim = cfg_data[LIMIT_BITS-1:0];

	// Thresholds are worked out once per write so the enqueue path only compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q   <= T1_RESET;
			t2_q   <= T2_RESET;
			node_q <= NODE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUEUE_LIMIT: begin
					t1_q <= div3({1'b0, qlim});
					t2_q <= div3({qlim, 1'b0});
				end
				REG_NODE_ADDRESS: begin
					node_q <= cfg_data[ADDR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign thr.t1   = t1_q;
	assign thr.t2   = t2_q;
	assign thr.node = node_q;

endmodule
`default_nettype wire

FILE: rtl/dual_queue_admission_round_robin.sv
// Top level: two handle FIFOs in RAM with occupancy admission and round-robin service.
// Enqueue: result is registered and shown in the cycle after the input beat; the next item
// can be taken in the following cycle. Dequeue: the head entry is read from RAM into the RAM
// read register and then moved to the output register; a new item is taken once it is there.
// A new item also waits while a finished result is held by a stalled output.
// Reset clears state, heads, counts, turn (local first) and output valid; RAM and data stay.
`default_nettype none
module dual_queue_admission_round_robin
	import dqa_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire item_t                    req,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output result_t                       rsp,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int CMPW = (SW > THR_BITS) ? SW : THR_BITS;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t  st_q;
	thr_t    thr;

	logic [AW-1:0] lh_q, fh_q;
	logic [CW-1:0] lc_q, fc_q;
	logic          turn_q;
	logic          from_local_s1, got_s1;
	result_t       rsp_q;
	logic          rsp_valid_q;

	logic                   accept, out_free, is_enq, is_deq;
	logic [SW-1:0]          total;
	logic [1:0]             bstate;
	logic                   is_local, full, admit;
	logic                   we_l, we_f;
	logic [AW-1:0]          tail;
	logic [SW-1:0]          tail_sum;
	logic                   l_nz, f_nz, got, from_local, turn_d;
	logic                   pop_l, pop_f;
	logic [HANDLE_BITS-1:0] rd_l, rd_f;
	result_t                enq_res, deq_res;

	assign cfg_ready = 1'b1;

	dqa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (st_q == ST_READ) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign is_enq    = accept && (req.mode == MODE_ENQ);
	assign is_deq    = accept && (req.mode == MODE_DEQ);

	// Admission on the combined occupancy before the insert.
	always_comb begin
		total    = SW'(lc_q) + SW'(fc_q);
		is_local = (req.source_address == thr.node);
		if (CMPW'(total) > CMPW'(thr.t2)) begin
			bstate = BS_REJECT;
		end else if (CMPW'(total) < CMPW'(thr.t1)) begin
			bstate = BS_ACCEPT;
		end else begin
			bstate = BS_FILTER;
		end
		full  = is_local ? (lc_q >= CW'(FIFO_DEPTH)) : (fc_q >= CW'(FIFO_DEPTH));
		admit = (bstate != BS_REJECT) && !full;
		tail_sum = is_local ? (SW'(lh_q) + SW'(lc_q)) : (SW'(fh_q) + SW'(fc_q));
		if (tail_sum >= SW'(FIFO_DEPTH)) begin
			tail_sum = tail_sum - SW'(FIFO_DEPTH);
		end
		tail = tail_sum[AW-1:0];
		we_l = is_enq && admit && is_local;
		we_f = is_enq && admit && !is_local;

		enq_res                = '0;
		enq_res.admitted       = admit;
		enq_res.buffer_state   = bstate;
		enq_res.went_local     = is_local;
		enq_res.overflow_drop  = (bstate != BS_REJECT) && full;
	end

	// Round robin: an empty FIFO on its turn yields to the other and keeps the turn.
	always_comb begin
		l_nz = (lc_q != '0);
		f_nz = (fc_q != '0);
		got  = l_nz || f_nz;
		if (turn_q) begin
			from_local = l_nz;
			turn_d     = !l_nz;
		end else begin
			from_local = !f_nz && l_nz;
			turn_d     = f_nz;
		end
		pop_l = is_deq && got && from_local;
		pop_f = is_deq && got && !from_local;
	end

	dqa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(FIFO_DEPTH)) u_local_ram (
		.clk   (clk),
		.we    (we_l),
		.waddr (tail),
		.wdata (req.packet_handle),
		.re    (is_deq),
		.raddr (lh_q),
		.rdata (rd_l)
	);

	dqa_ram #(.WIDTH(HANDLE_BITS), .DEPTH(FIFO_DEPTH)) u_forward_ram (
		.clk   (clk),
		.we    (we_f),
		.waddr (tail),
		.wdata (req.packet_handle),
		.re    (is_deq),
		.raddr (fh_q),
		.rdata (rd_f)
	);

	always_comb begin
		deq_res                = '0;
		deq_res.out_valid      = got_s1;
		deq_res.out_from_local = got_s1 && from_local_s1;
		if (got_s1) begin
			deq_res.out_handle = from_local_s1 ? rd_l : rd_f;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			lh_q   <= '0;
			fh_q   <= '0;
			lc_q   <= '0;
			fc_q   <= '0;
			turn_q <= 1'b1;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (is_deq) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (we_l) begin
				lc_q <= lc_q + CW'(1);
			end else if (pop_l) begin
				lc_q <= lc_q - CW'(1);
				lh_q <= (lh_q == AW'(FIFO_DEPTH - 1)) ? '0 : lh_q + AW'(1);
			end
			if (we_f) begin
				fc_q <= fc_q + CW'(1);
			end else if (pop_f) begin
				fc_q <= fc_q - CW'(1);
				fh_q <= (fh_q == AW'(FIFO_DEPTH - 1)) ? '0 : fh_q + AW'(1);
			end
			if (is_deq) begin
				turn_q <= turn_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_deq) begin
			from_local_s1 <= from_local;
			got_s1        <= got;
		end
	end

	// Output register: loaded by an enqueue at once or by a dequeue after its RAM read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_enq || (st_q == ST_READ)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_enq) begin
			rsp_q <= enq_res;
		end else if (st_q == ST_READ) begin
			rsp_q <= deq_res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n) !(we_l && we_f))
		else $error("both FIFO memories written in one cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(lc_q <= CW'(FIFO_DEPTH)) && (fc_q <= CW'(FIFO_DEPTH)))
		else $error("FIFO count above depth");

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> !rsp_valid_q)
		else $error("dequeue read data arrives while output register is occupied");

	a_deq_reads: assert property (@(posedge clk) disable iff (!arst_n)
		is_deq |=> (st_q == ST_READ))
		else $error("accepted dequeue did not enter the read cycle");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(is_enq || (st_q == ST_READ)) |=> rsp_valid_q)
		else $error("finished item did not reach the output register");

endmodule
`default_nettype wire
